### design/rss_pkg.sv
package rss_pkg;

   localparam int ELEM_WIDTH  = 32;
   localparam int RANGE_WIDTH = 5;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_FIRST = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RANGE_LAST  = 2'd1;

   localparam logic [RANGE_WIDTH-1:0] RANGE_FIRST_RESET = 5'd0;
   localparam logic [RANGE_WIDTH-1:0] RANGE_LAST_RESET  = 5'd31;

   typedef enum logic [1:0] {
      PHASE_LOADING,
      PHASE_SORTING,
      PHASE_EMITTING
   } phase_type;

   // Per-cell control signals.
   typedef struct packed {
      logic write_en;
      logic shift_en;
      logic pair_en;
   } cell_ctrl_type;

endpackage

### design/rss_cell.sv
module rss_cell (
   input  logic                              clock,
   input  rss_pkg::cell_ctrl_type            ctrl,
   input  logic [rss_pkg::ELEM_WIDTH-1:0]    write_value,
   input  logic [rss_pkg::ELEM_WIDTH-1:0]    left_value,
   input  logic [rss_pkg::ELEM_WIDTH-1:0]    right_value,
   input  logic                              left_swap,
   output logic [rss_pkg::ELEM_WIDTH-1:0]    value,
   output logic                              swap_out
);
   import rss_pkg::*;

   logic [ELEM_WIDTH-1:0] value_ff;
   logic [ELEM_WIDTH-1:0] value_in;

   // This cell is the left member of a compare pair when pair_en is set;
   // the pair swaps when the right neighbor holds the smaller value.
   assign swap_out = ctrl.pair_en && ($signed(right_value) < $signed(value_ff));
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.write_en) begin
         value_in = write_value;
      end else if (ctrl.shift_en || swap_out) begin
         value_in = right_value;
      end else if (left_swap) begin
         value_in = left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### design/range_selection_sort_top.sv
// Elements are loaded one per cycle while busy is low; a transaction marked
// last starts the sort, after which busy stays high through the odd-even
// compare-exchange sweeps across the row of cells (positions range_first to
// the clamped range_last only), followed by one result per cycle for every
// loaded element, position 0 first, on rsp_strobe. The receiver cannot stall:
// each result is valid for exactly one cycle. Elements arriving once
// MAX_ELEMENTS are held are dropped.
module range_selection_sort_top #(
   parameter int MAX_ELEMENTS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [rss_pkg::ELEM_WIDTH-1:0] req_element_value,
   input  logic                                  req_is_last_element,
   output logic                                  rsp_strobe,
   output logic signed [rss_pkg::ELEM_WIDTH-1:0] rsp_result_value,
   output logic                                  rsp_is_last_result,
   input  logic                                  csr_write_enable,
   input  logic [rss_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rss_pkg::RANGE_WIDTH-1:0]       csr_write_data
);
   import rss_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int SW = $clog2(MAX_ELEMENTS);
   localparam int HW = (CW > RANGE_WIDTH) ? CW : RANGE_WIDTH;

   phase_type            phase_ff, phase_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        sweep_ff, sweep_in;
   logic [RANGE_WIDTH-1:0] range_first_ff, range_last_ff;

   logic                 accept;
   logic [HW-1:0]        lo, hi, count_m1, last_ext;

   cell_ctrl_type        ctrl   [MAX_ELEMENTS];
   logic [ELEM_WIDTH-1:0] values [MAX_ELEMENTS];
   logic                 swaps  [MAX_ELEMENTS];

   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_first_ff <= RANGE_FIRST_RESET;
         range_last_ff  <= RANGE_LAST_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RANGE_FIRST: range_first_ff <= csr_write_data;
            CSR_RANGE_LAST:  range_last_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Clamp the range end to the last loaded position.
   assign lo       = HW'(range_first_ff);
   assign last_ext = HW'(range_last_ff);
   assign count_m1 = HW'(count_ff) - HW'(1);
   assign hi       = (last_ext > count_m1) ? count_m1 : last_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_LOADING;
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      count_in           = count_ff;
      sweep_in           = sweep_ff;
      busy               = 1'b1;
      rsp_strobe         = 1'b0;
      rsp_is_last_result = 1'b0;
      case (phase_ff)
         PHASE_LOADING: begin
            busy = 1'b0;
            if (start) begin
               if (count_ff < CW'(MAX_ELEMENTS)) begin
                  count_in = count_ff + CW'(1);
               end
               if (req_is_last_element) begin
                  phase_in = PHASE_SORTING;
                  sweep_in = '0;
               end
            end
         end
         PHASE_SORTING: begin
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == SW'(MAX_ELEMENTS - 1)) begin
               phase_in = PHASE_EMITTING;
            end
         end
         PHASE_EMITTING: begin
            rsp_strobe         = 1'b1;
            rsp_is_last_result = (count_ff == CW'(1));
            count_in           = count_ff - CW'(1);
            if (count_ff == CW'(1)) begin
               phase_in = PHASE_LOADING;
            end
         end
         default: begin
            phase_in = PHASE_LOADING;
         end
      endcase
   end

   assign rsp_result_value = values[0];

   genvar i;
   generate
      for (i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
         logic [ELEM_WIDTH-1:0] left_v, right_v;
         logic                  left_s;

         assign ctrl[i].write_en = accept && (count_ff == CW'(i));
         assign ctrl[i].shift_en = (phase_ff == PHASE_EMITTING);

         if (i == MAX_ELEMENTS - 1) begin : g_end
            assign ctrl[i].pair_en = 1'b0;
            assign right_v         = values[i];
         end else begin : g_mid
            // Pairs alternate between even and odd left positions each sweep.
            assign ctrl[i].pair_en = (phase_ff == PHASE_SORTING)
                                     && (sweep_ff[0] == 1'(i % 2))
                                     && (HW'(i) >= lo) && (HW'(i) < hi);
            assign right_v         = values[i+1];
         end

         if (i == 0) begin : g_first
            assign left_v = values[i];
            assign left_s = 1'b0;
         end else begin : g_rest
            assign left_v = values[i-1];
            assign left_s = swaps[i-1];
         end

         rss_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[i]),
            .write_value (req_element_value),
            .left_value  (left_v),
            .right_value (right_v),
            .left_swap   (left_s),
            .value       (values[i]),
            .swap_out    (swaps[i])
         );
      end
   endgenerate

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_last_element) |=> (busy && !rsp_strobe))
      else $error("last element did not start the sort");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_last_result) |=> !busy)
      else $error("block stayed busy after the final result");

   a_flag_with_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_is_last_result |-> rsp_strobe)
      else $error("last flag without strobe");

endmodule
